>>> hdl/mpe_pkg.sv
`timescale 1ns / 1ps

package mpe_pkg;

	localparam int COUNT_BITS_DEF = 8;

	// phoneme letters with a meaning of their own
	localparam logic [7:0] SH_CODE = 8'h58;  // 'X'
	localparam logic [7:0] TH_CODE = 8'h30;  // '0'

	// result queue
	localparam int RQ_DEPTH = 8;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = RQ_PTR_W + 1;
	localparam int RQ_SLOTS = 3;  // most words written by one engine step

	// register index, taken from paddr[2]
	localparam logic REG_LIMIT = 1'b0;
	localparam logic REG_MODE  = 1'b1;

	typedef struct packed {
		logic [7:0] phoneme;
		logic       no_phoneme;
		logic       last;
	} res_t;

	// byte window around the position under decode
	typedef struct packed {
		logic [7:0] cur;
		logic [7:0] prev;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] n1;
		logic [7:0] n2;
		logic [7:0] n3;
	} win_t;

	typedef struct packed {
		logic [1:0] n_emit;
		logic [7:0] ph0;
		logic [7:0] ph1;
		logic [1:0] skip;
		logic       first_done;
	} dec_res_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		fold_case = (c inside {[8'h61:8'h7A]}) ? (c - 8'd32) : c;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		is_letter = c inside {[8'h41:8'h5A]};
	endfunction

	function automatic logic vowel_byte(input logic [7:0] c);
		vowel_byte = c inside {"A", "E", "I", "O", "U"};
	endfunction

	function automatic logic blocks_h(input logic [7:0] c);
		blocks_h = c inside {"C", "G", "P", "S", "T"};
	endfunction

endpackage

>>> hdl/mpe_decode.sv
`timescale 1ns / 1ps

module mpe_decode import mpe_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  win_t                  win,
	input  logic [1:0]            skip,
	input  logic                  first_done,
	input  logic [COUNT_BITS-1:0] count,
	input  logic [7:0]            limit,
	input  logic                  trad,
	output dec_res_t              res,
	output logic [COUNT_BITS-1:0] count_next
);

	localparam int CW = (COUNT_BITS > 8) ? COUNT_BITS : 8;

	function automatic logic at_cap(input logic [COUNT_BITS-1:0] c, input logic [7:0] lim);
		at_cap = (lim != 8'd0) && (CW'(c) >= CW'(lim));
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		sat_inc = (c == '1) ? c : c + 1'b1;
	endfunction

	logic                  handled;
	logic                  refined;
	logic [1:0]            want;
	logic [7:0]            w0;
	logic [7:0]            w1;
	logic [1:0]            skip_n;
	logic                  first_n;
	logic                  ok0;
	logic                  ok1;
	logic                  e0;
	logic                  e1;
	logic [COUNT_BITS-1:0] cnt1;

	assign refined = ~trad;
	assign cnt1    = sat_inc(count);
	assign ok0     = ~at_cap(count, limit);
	assign ok1     = ~at_cap(cnt1, limit);

	always_comb begin
		handled = 1'b0;
		want    = 2'd0;
		w0      = 8'h00;
		w1      = 8'h00;
		skip_n  = skip;
		first_n = first_done;
		if (skip != 2'd0) begin
			skip_n = skip - 2'd1;
		end else if (is_letter(win.cur)) begin
			first_n = 1'b1;
			if (!first_done) begin
				case (win.cur)
					"A": begin
						handled = 1'b1;
						want    = 2'd1;
						if (win.n1 == "E") begin
							w0     = "E";
							skip_n = 2'd1;
						end else begin
							w0 = "A";
						end
					end
					"G", "K", "P": begin
						if (win.n1 == "N") begin
							handled = 1'b1;
							want    = 2'd1;
							w0      = "N";
							skip_n  = 2'd1;
						end
					end
					"W": begin
						if (win.n1 == "R") begin
							handled = 1'b1;
							want    = 2'd1;
							w0      = "R";
							skip_n  = 2'd1;
						end else if (win.n1 == "H" || vowel_byte(win.n1)) begin
							handled = 1'b1;
							want    = 2'd1;
							w0      = "W";
							skip_n  = 2'd1;
						end
					end
					"X": begin
						handled = 1'b1;
						want    = 2'd1;
						w0      = "S";
					end
					"E", "I", "O", "U": begin
						handled = 1'b1;
						want    = 2'd1;
						w0      = win.cur;
					end
					default: ;
				endcase
			end
			// a capped word still skips nothing through the main rules
			if (!handled && ok0 && !(win.cur == win.prev && win.cur != "C")) begin
				case (win.cur)
					"B": begin
						if (win.prev != "M") begin
							want = 2'd1;
							w0   = "B";
						end
					end
					"C": begin
						want = 2'd1;
						if (win.n1 == "H") begin
							w0     = (refined && (win.prev == "S" || win.n2 == "R")) ? "K" : SH_CODE;
							skip_n = 2'd1;
						end else if (win.n1 == "I" && win.n2 inside {"A", "E", "Y"}) begin
							w0 = SH_CODE;
						end else if (refined && win.n1 == "C" && win.n2 == "H" && win.n3 == "W") begin
							w0     = SH_CODE;
							skip_n = 2'd2;
						end else begin
							w0 = "K";
						end
					end
					"D": begin
						want = 2'd1;
						if (win.n1 == "G" && win.n2 inside {"I", "E", "Y"}) begin
							w0     = "J";
							skip_n = 2'd1;
						end else begin
							w0 = "T";
						end
					end
					"G": begin
						if (win.n1 == "H") begin
							if (!(win.b3 == "B" || win.b2 == "D" || win.b2 == "H" ||
								win.prev == "H")) begin
								want   = 2'd1;
								w0     = "F";
								skip_n = 2'd1;
							end
						end else if (win.n1 == "N" && is_letter(win.n2) && !is_letter(win.n3)) begin
							want = 2'd1;
							w0   = "K";
						end else if (win.n1 == "E" && win.n2 inside {"Y", "I", "E"}) begin
							if (win.prev != "G") begin
								want = 2'd1;
								w0   = "J";
							end
						end else begin
							want = 2'd1;
							w0   = "K";
						end
					end
					"H": begin
						if (vowel_byte(win.n1) && !blocks_h(win.prev)) begin
							want = 2'd1;
							w0   = "H";
						end
					end
					"K": begin
						if (win.prev != "C") begin
							want = 2'd1;
							w0   = "K";
						end
					end
					"P": begin
						want = 2'd1;
						w0   = (win.n1 == "H") ? "F" : "P";
					end
					"Q": begin
						want = 2'd1;
						w0   = "K";
					end
					"S", "T": begin
						want = 2'd1;
						if (win.n1 == "I" && win.n2 inside {"O", "A"}) begin
							w0 = SH_CODE;
						end else if (win.n1 == "H") begin
							w0 = (win.cur == "S") ? SH_CODE : TH_CODE;
						end else if (win.cur == "S") begin
							w0 = (refined && win.n1 == "C" && win.n2 == "H" && win.n3 == "W") ?
								SH_CODE : "S";
						end else if (win.n1 == "C" && win.n2 == "H") begin
							want = 2'd0;  // TCH: the CH carries the sound
						end else begin
							w0 = "T";
						end
					end
					"V": begin
						want = 2'd1;
						w0   = "F";
					end
					"W", "Y": begin
						if (vowel_byte(win.n1)) begin
							want = 2'd1;
							w0   = win.cur;
						end
					end
					"X": begin
						want = 2'd2;
						w0   = "K";
						w1   = "S";
					end
					"Z": begin
						want = 2'd1;
						w0   = "S";
					end
					"F", "J", "L", "M", "N", "R": begin
						want = 2'd1;
						w0   = win.cur;
					end
					default: ;
				endcase
			end
		end
	end

	// each phoneme checks the cap on its own, so KS can stop after the K
	assign e0 = (want != 2'd0) && ok0;
	assign e1 = (want == 2'd2) && e0 && ok1;

	assign count_next = e1 ? sat_inc(cnt1) : (e0 ? cnt1 : count);

	assign res.n_emit     = {1'b0, e0} + {1'b0, e1};
	assign res.ph0        = w0;
	assign res.ph1        = w1;
	assign res.skip       = skip_n;
	assign res.first_done = first_n;

endmodule

>>> hdl/mpe_result_queue.sv
`timescale 1ns / 1ps

module mpe_result_queue import mpe_pkg::*; #(
	parameter int DEPTH = RQ_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 wr_n,
	input  res_t [RQ_SLOTS-1:0]        wr_data,
	input  logic                       rd_ready,
	output logic                       rd_valid,
	output res_t                       rd_data,
	output logic [$clog2(DEPTH):0]     count
);

	localparam int PW = $clog2(DEPTH);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          pop;

	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign pop      = rd_valid & rd_ready;
	assign count    = count_q;

	always_ff @(posedge clk) begin
		for (int k = 0; k < RQ_SLOTS; k++) begin
			if (2'(k) < wr_n) begin
				mem_q[wr_ptr_q + PW'(k)] <= wr_data[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(wr_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PW + 1)'(wr_n) - (PW + 1)'(pop);
		end
	end

endmodule

>>> hdl/metaphone_phonetic_encoder.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata[7:0] char_code; tlast word_end
// m_*       out  m_tvalid/m_tready  tdata[7:0] phoneme; tuser no_phoneme; tlast last
// APB       in   psel/penable       0x0 phoneme_limit[7:0]; 0x4 traditional_mode[0]
//
// One byte is taken per cycle while the queue has room and no word is draining;
// a position is decoded once three bytes follow it. After the last byte of a
// word the single rule decoder drains the look-ahead window (one to four bytes).
// Words go out one per cycle while m_tready is high, from an 8-entry queue;
// input stalls while fewer than three entries are free.
// Reset clears the windows, word state and queue, and loads limit 0, mode 1.

module metaphone_phonetic_encoder import mpe_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] phoneme
	output logic        m_tuser,   // [0] no_phoneme
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// config registers
	logic [7:0] limit_q;
	logic       trad_q;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;

	// word state
	logic [7:0]            ahead_q  [4];
	logic [7:0]            behind_q [3];
	logic [1:0]            fill_q;
	logic [1:0]            skip_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  first_q;
	logic                  flush_q;
	logic                  hold_v_q;
	logic [7:0]            hold_ph_q;

	logic [7:0]            view [4];
	logic [2:0]            fill_eff;
	logic [2:0]            fill_after;
	logic                  room;
	logic                  step_push;
	logic                  step_flush;
	logic                  step;
	logic                  dec_en;
	logic                  in_end;
	logic                  final_step;
	win_t                  win;
	dec_res_t              dec;
	logic [COUNT_BITS-1:0] count_next;
	logic [1:0]            e_n;
	logic                  p_hold;
	logic                  p0;
	logic                  p1;
	res_t [RQ_SLOTS-1:0]   slot;
	logic [1:0]            wr_n;
	res_t                  head;
	logic [RQ_CNT_W-1:0]   q_count;

	// ---------------- APB ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 8'd0;
			trad_q  <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_LIMIT: limit_q <= pwdata[7:0];
				REG_MODE:  trad_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[1:0] == 2'd0) begin
			case (paddr[2])
				REG_LIMIT: prdata = {24'd0, limit_q};
				REG_MODE:  prdata = {31'd0, trad_q};
				default:   prdata = 32'd0;
			endcase
		end
	end

	// ---------------- step control ----------------
	assign room       = (q_count <= RQ_CNT_W'(RQ_DEPTH - RQ_SLOTS));
	assign step_push  = valid_s1 && !flush_q && room;
	assign step_flush = flush_q && room;
	assign step       = step_push || step_flush;
	assign s_tready   = !valid_s1 || step_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= fold_case(s_tdata);
			end_s1  <= s_tlast;
		end
	end

	// window as the decoder sees it, with this cycle's byte written in
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			view[i] = (step_push && fill_q == 2'(i)) ? char_s1 : ahead_q[i];
		end
	end

	assign fill_eff   = {1'b0, fill_q} + {2'b00, step_push};
	assign fill_after = fill_eff - 3'd1;
	assign in_end     = step_flush || (step_push && end_s1);
	assign dec_en     = in_end || (step_push && fill_eff == 3'd4);
	assign final_step = in_end && (fill_after == 3'd0);

	assign win.cur  = view[0];
	assign win.prev = behind_q[0];
	assign win.b2   = behind_q[1];
	assign win.b3   = behind_q[2];
	assign win.n1   = view[1];
	assign win.n2   = view[2];
	assign win.n3   = view[3];

	mpe_decode #(
		.COUNT_BITS (COUNT_BITS)
	) u_decode (
		.win        (win),
		.skip       (skip_q),
		.first_done (first_q),
		.count      (count_q),
		.limit      (limit_q),
		.trad       (trad_q),
		.res        (dec),
		.count_next (count_next)
	);

	assign e_n = dec_en ? dec.n_emit : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) ahead_q[i] <= 8'h00;
			for (int i = 0; i < 3; i++) behind_q[i] <= 8'h00;
			fill_q    <= 2'd0;
			skip_q    <= 2'd0;
			count_q   <= '0;
			first_q   <= 1'b0;
			flush_q   <= 1'b0;
			hold_v_q  <= 1'b0;
			hold_ph_q <= 8'h00;
		end else if (step) begin
			if (final_step) begin
				for (int i = 0; i < 4; i++) ahead_q[i] <= 8'h00;
				for (int i = 0; i < 3; i++) behind_q[i] <= 8'h00;
				fill_q   <= 2'd0;
				skip_q   <= 2'd0;
				count_q  <= '0;
				first_q  <= 1'b0;
				flush_q  <= 1'b0;
				hold_v_q <= 1'b0;
			end else if (dec_en) begin
				for (int i = 0; i < 3; i++) ahead_q[i] <= view[i+1];
				ahead_q[3]  <= 8'h00;
				behind_q[0] <= view[0];
				behind_q[1] <= behind_q[0];
				behind_q[2] <= behind_q[1];
				fill_q      <= fill_after[1:0];
				skip_q      <= dec.skip;
				count_q     <= count_next;
				first_q     <= dec.first_done;
				flush_q     <= in_end;
				// inside the closing run the newest word waits for its last flag
				if (in_end && e_n != 2'd0) begin
					hold_v_q  <= 1'b1;
					hold_ph_q <= (e_n == 2'd2) ? dec.ph1 : dec.ph0;
				end
			end else begin
				for (int i = 0; i < 4; i++) ahead_q[i] <= view[i];
				fill_q <= fill_eff[1:0];
			end
		end
	end

	// ---------------- queue writes ----------------
	always_comb begin
		p_hold = 1'b0;
		p0     = 1'b0;
		p1     = 1'b0;
		if (step) begin
			if (!in_end) begin
				p0 = (e_n != 2'd0);
				p1 = (e_n == 2'd2);
			end else if (!final_step) begin
				p_hold = hold_v_q && (e_n != 2'd0);
				p0     = (e_n == 2'd2);
			end else begin
				p_hold = hold_v_q;
				p0     = (e_n != 2'd0);
				p1     = (e_n == 2'd2);
			end
		end
	end

	always_comb begin
		slot = '0;
		wr_n = 2'd0;
		if (p_hold) begin
			slot[wr_n] = '{phoneme: hold_ph_q, no_phoneme: 1'b0, last: 1'b0};
			wr_n       = wr_n + 2'd1;
		end
		if (p0) begin
			slot[wr_n] = '{phoneme: dec.ph0, no_phoneme: 1'b0, last: 1'b0};
			wr_n       = wr_n + 2'd1;
		end
		if (p1) begin
			slot[wr_n] = '{phoneme: dec.ph1, no_phoneme: 1'b0, last: 1'b0};
			wr_n       = wr_n + 2'd1;
		end
		if (step && final_step) begin
			if (wr_n == 2'd0) begin
				// nothing came out at the close: a marker word ends the word
				slot[0] = '{phoneme: 8'h00, no_phoneme: (count_q == '0), last: 1'b1};
				wr_n    = 2'd1;
			end else begin
				slot[wr_n - 2'd1].last = 1'b1;
			end
		end
	end

	mpe_result_queue #(
		.DEPTH (RQ_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_n     (wr_n),
		.wr_data  (slot),
		.rd_ready (m_tready),
		.rd_valid (m_tvalid),
		.rd_data  (head),
		.count    (q_count)
	);

	assign m_tdata = head.phoneme;
	assign m_tuser = head.no_phoneme;
	assign m_tlast = head.last;

	// ---------------- checks ----------------
	a_hold_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> flush_q)
		else $error("held word outside a word close");

	a_drain_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> (fill_q != 2'd0))
		else $error("draining with an empty window");

	a_word_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && final_step) |=> (fill_q == 2'd0 && count_q == '0 && !first_q &&
			!hold_v_q && !flush_q))
		else $error("word state not cleared after word close");

	a_skip_range: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q != 2'd3)
		else $error("skip count out of range");

endmodule
